>>> src/caf_pkg.sv
// Package for the CPU ALU flag unit: payload structs and flag-update operation codes.
// It has no dependencies. The flag logic and the top level use it.
`default_nettype none

package caf_pkg;

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_ADC        = 5'd1,
    OP_SUB        = 5'd2,
    OP_SUB_SELF   = 5'd3,
    OP_SBC        = 5'd4,
    OP_SBC_KEEP_C = 5'd5,
    OP_AND        = 5'd6,
    OP_XOR        = 5'd7,
    OP_XOR_SELF   = 5'd8,
    OP_OR         = 5'd9,
    OP_INC        = 5'd10,
    OP_DEC        = 5'd11,
    OP_CPL        = 5'd12,
    OP_ADD16      = 5'd13,
    OP_ADD_SP     = 5'd14,
    OP_ROT_ACC    = 5'd15,
    OP_ROT        = 5'd16,
    OP_SWAP       = 5'd17,
    OP_BIT        = 5'd18
  } op_t;

  typedef struct packed {
    logic [4:0]  operation;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic        shifted_out_bit;
  } in_item_t;

  typedef struct packed {
    logic zero_out;
    logic subtract_out;
    logic half_carry_out;
    logic carry_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/cpu_alu_flag_unit.sv
// Top level of the CPU ALU flag unit: input register, flag state and result register.
// Depends on caf_pkg and on caf_flag_calc for the flag update of one transaction.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries one flag-update
// transaction: an operation code, two 16-bit operands and the bit rotated out.
// The result channel (out_valid, out_ready, out_data) returns the four updated
// flags, one result transaction for every input transaction, in order.
// A transaction is held in the input register, its flags are computed from it and
// from the stored flags, and they land in the result register and the flag state
// together. An accepted transaction passes through the input register and then, when
// the result register is free or being emptied, moves into it and raises out_valid.
// Throughput is one transaction per cycle while the receiver keeps out_ready high; the carry
// kept from one transaction feeds the next one's add or subtract with carry without a bubble.
// When the receiver stalls, the result register holds and the input register fills;
// in_ready then drops until the result is taken.
// Synchronous reset clears the flags to zero and empties both registers.
`default_nettype none

module cpu_alu_flag_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire caf_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output caf_pkg::out_item_t       out_data
);

  logic                s1_valid_r;
  caf_pkg::in_item_t   s1_item_r;
  logic                out_valid_r;
  caf_pkg::out_item_t  out_data_r;
  caf_pkg::out_item_t  flags_r;
  caf_pkg::out_item_t  flags_nxt;
  logic                s1_adv;
  logic                in_take;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  caf_flag_calc u_calc (
    .item      (s1_item_r),
    .flags_cur (flags_r),
    .flags_nxt (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= flags_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A transaction that leaves the input register shows up as a result next cycle.
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced transaction did not reach the result register");

  // A pending result always matches the flag state.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flags_r == out_data_r))
    else $error("result register and flag state disagree");

  // Input backpressure only when both registers are occupied and the output stalls.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full pipeline");

endmodule

`default_nettype wire

>>> src/caf_flag_calc.sv
// Combinational flag update for one transaction of the CPU ALU flag unit.
// Depends on caf_pkg for the payload structs and the operation codes.
`default_nettype none

module caf_flag_calc (
  input  wire caf_pkg::in_item_t  item,
  input  wire caf_pkg::out_item_t flags_cur,
  output caf_pkg::out_item_t      flags_nxt
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        add_c;
  logic        sub_c;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [7:0]  sub_diff;
  logic        sub_half;
  logic        sub_borrow;
  logic [12:0] add16_half;
  logic [16:0] add16_sum;

  assign a   = item.first_operand[7:0];
  assign b   = item.second_operand[7:0];
  assign cin = flags_cur.carry_out;

  assign add_c    = (caf_pkg::op_t'(item.operation) == caf_pkg::OP_ADC) ? cin : 1'b0;
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, add_c};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_c};

  assign sub_c      = (caf_pkg::op_t'(item.operation) == caf_pkg::OP_SUB) ? 1'b0 : cin;
  assign sub_diff   = a - b - {7'd0, sub_c};
  assign sub_half   = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, sub_c});
  assign sub_borrow = {1'b0, a} < ({1'b0, b} + {8'd0, sub_c});

  assign add16_half = {1'b0, item.first_operand[11:0]} + {1'b0, item.second_operand[11:0]};
  assign add16_sum  = {1'b0, item.first_operand} + {1'b0, item.second_operand};

  always_comb begin
    flags_nxt = flags_cur;
    unique case (caf_pkg::op_t'(item.operation))
      caf_pkg::OP_ADD, caf_pkg::OP_ADC: begin
        flags_nxt = '{(add_sum[7:0] == 8'd0), 1'b0, add_half[4], add_sum[8]};
      end
      caf_pkg::OP_SUB, caf_pkg::OP_SBC: begin
        flags_nxt = '{(sub_diff == 8'd0), 1'b1, sub_half, sub_borrow};
      end
      caf_pkg::OP_SBC_KEEP_C: begin
        flags_nxt = '{(sub_diff == 8'd0), 1'b1, sub_half, cin};
      end
      caf_pkg::OP_SUB_SELF: begin
        flags_nxt = '{1'b1, 1'b1, 1'b0, 1'b0};
      end
      caf_pkg::OP_AND: begin
        flags_nxt = '{((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      caf_pkg::OP_XOR: begin
        flags_nxt = '{((a ^ b) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      caf_pkg::OP_XOR_SELF: begin
        flags_nxt = '{1'b1, 1'b0, 1'b0, 1'b0};
      end
      caf_pkg::OP_OR: begin
        flags_nxt = '{((a | b) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      caf_pkg::OP_INC: begin
        flags_nxt = '{(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
      end
      caf_pkg::OP_DEC: begin
        flags_nxt = '{(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
      end
      caf_pkg::OP_CPL: begin
        flags_nxt = '{flags_cur.zero_out, 1'b1, 1'b1, cin};
      end
      caf_pkg::OP_ADD16: begin
        flags_nxt = '{flags_cur.zero_out, 1'b0, add16_half[12], add16_sum[16]};
      end
      caf_pkg::OP_ADD_SP: begin
        flags_nxt = '{1'b0, 1'b0, add_half[4], add_sum[8]};
      end
      caf_pkg::OP_ROT_ACC: begin
        flags_nxt = '{1'b0, 1'b0, 1'b0, item.shifted_out_bit};
      end
      caf_pkg::OP_ROT: begin
        flags_nxt = '{(a == 8'd0), 1'b0, 1'b0, item.shifted_out_bit};
      end
      caf_pkg::OP_SWAP: begin
        flags_nxt = '{(a == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      caf_pkg::OP_BIT: begin
        flags_nxt = '{(a == 8'd0), 1'b0, 1'b1, cin};
      end
      default: begin
        flags_nxt = flags_cur;
      end
    endcase
  end

endmodule

`default_nettype wire
